>>> rtl/swm_pkg.sv
// Shared constants and types for the sliding window maximum block.
// Used by swm_cell and sliding_window_maximum; depends on nothing.
package swm_pkg;

  localparam int MAX_WINDOW_DEF   = 64;
  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int AGE_WIDTH_DEF    = $clog2(MAX_WINDOW_DEF + 1);
  localparam int CFG_WIDTH        = 7;

  // Control broadcast from the top level to every cell.
  typedef struct packed {
    logic step;   // a word is accepted this cycle
    logic start;  // the accepted word opens a new sequence
    logic shift;  // front candidate leaves; every cell takes its right neighbor
    logic clear;  // window size written: drop all candidates
  } swm_ctrl_t;

endpackage

>>> rtl/swm_cell.sv
// One queue slot of the sliding window maximum: a candidate value and its age.
// Depends on swm_pkg (swm_ctrl_t and default widths).
module swm_cell #(
  parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF,
  parameter int AGE_WIDTH    = swm_pkg::AGE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  swm_pkg::swm_ctrl_t             ctrl,
  input  logic        [AGE_WIDTH-1:0]    win,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  // state of the right neighbor (toward the back of the queue)
  input  logic                           nbr_valid,
  input  logic signed [SAMPLE_WIDTH-1:0] nbr_value,
  input  logic        [AGE_WIDTH-1:0]    nbr_age,
  // left neighbor keeps its candidate
  input  logic                           prev_keep,
  output logic                           keep,
  output logic                           state_valid,
  output logic signed [SAMPLE_WIDTH-1:0] state_value,
  output logic        [AGE_WIDTH-1:0]    state_age,
  output logic signed [SAMPLE_WIDTH-1:0] nxt_value,
  output logic                           expired
);

  logic                           valid_r, valid_nxt;
  logic signed [SAMPLE_WIDTH-1:0] value_r, value_nxt;
  logic        [AGE_WIDTH-1:0]    age_r, age_nxt;

  logic                           cand_valid;
  logic signed [SAMPLE_WIDTH-1:0] cand_value;
  logic        [AGE_WIDTH-1:0]    cand_age;

  always_comb begin
    cand_valid = ctrl.start ? 1'b0 : (ctrl.shift ? nbr_valid : valid_r);
    cand_value = ctrl.shift ? nbr_value : value_r;
    cand_age   = ctrl.shift ? nbr_age : age_r;
    // ties stay: only strictly smaller candidates are dropped
    keep       = cand_valid && !(cand_value < sample);
    if (keep) begin
      valid_nxt = 1'b1;
      value_nxt = cand_value;
      age_nxt   = AGE_WIDTH'(cand_age + 1'b1);
    end else if (prev_keep) begin
      valid_nxt = 1'b1;
      value_nxt = sample;
      age_nxt   = '0;
    end else begin
      valid_nxt = 1'b0;
      value_nxt = cand_value;
      age_nxt   = cand_age;
    end
  end

  assign expired     = valid_r &&
                       (({1'b0, age_r} + 1'b1) >= {1'b0, win});
  assign state_valid = valid_r;
  assign state_value = value_r;
  assign state_age   = age_r;
  assign nxt_value   = value_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctrl.clear) begin
      valid_r <= 1'b0;
    end else if (ctrl.step) begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.step) begin
      value_r <= value_nxt;
      age_r   <= age_nxt;
    end
  end

endmodule

>>> rtl/sliding_window_maximum.sv
// Sliding window maximum: top level with the cell row, counters and output register.
// Depends on swm_pkg and swm_cell.
//
// Usage:
//   in_*  : one word per sample (in_sample, in_start_sequence), valid/ready.
//   out_* : one word (out_window_max) per sample once window_size samples of
//           the current sequence have arrived; earlier samples give no word.
//   cfg_* : write of window_size (0 acts as 1, above MAX_WINDOW acts as
//           MAX_WINDOW). A write also starts a new sequence. Write only while
//           the block is idle; cfg_ready is always high.
// Throughput: one word per cycle unless stalled. Every cell compares its candidate
//   with the new sample in the same cycle, and the row shifts by at most one slot.
// Output: the registered result shows in out_window_max the cycle after acceptance.
// Stall: the output register holds its word while out_ready is low; a new
//   word is taken in the cycle the output register drains or is empty.
// Reset: queue empty, sample count zero, window_size 1, no output word.
module sliding_window_maximum #(
  parameter int MAX_WINDOW   = swm_pkg::MAX_WINDOW_DEF,
  parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0]   in_sample,
  input  logic                             in_start_sequence,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [SAMPLE_WIDTH-1:0]   out_window_max,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [swm_pkg::CFG_WIDTH-1:0]    cfg_window_size
);

  localparam int AGE_WIDTH = $clog2(MAX_WINDOW + 1);

  // Queue row: cell 0 is the front (oldest, largest), higher index toward the back.
  logic                           row_valid [0:MAX_WINDOW];
  logic signed [SAMPLE_WIDTH-1:0] row_value [0:MAX_WINDOW];
  logic        [AGE_WIDTH-1:0]    row_age   [0:MAX_WINDOW];
  logic                           row_keep  [0:MAX_WINDOW];
  logic signed [SAMPLE_WIDTH-1:0] row_nxt   [0:MAX_WINDOW-1];
  logic                           row_exp   [0:MAX_WINDOW-1];

  swm_pkg::swm_ctrl_t ctrl;

  logic [AGE_WIDTH-1:0] win_r, win_nxt;
  logic [AGE_WIDTH-1:0] seen_r, seen_nxt, seen_base;
  logic                 out_valid_r;
  logic signed [SAMPLE_WIDTH-1:0] out_max_r;

  logic in_fire, cfg_fire, emit;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;

  // Only the front candidate can age out: ages along the row are distinct and
  // grow by one per sample, so at most one slot leaves per word.
  always_comb begin
    ctrl.step  = in_fire;
    ctrl.start = in_start_sequence;
    ctrl.shift = row_exp[0];
    ctrl.clear = cfg_fire;
  end

  // Beyond the last cell nothing is held; before the first the new sample may land.
  assign row_valid[MAX_WINDOW] = 1'b0;
  assign row_value[MAX_WINDOW] = '0;
  assign row_age[MAX_WINDOW]   = '0;
  assign row_keep[0]           = 1'b1;

  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    swm_cell #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .AGE_WIDTH    (AGE_WIDTH)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (ctrl),
      .win         (win_r),
      .sample      (in_sample),
      .nbr_valid   (row_valid[i+1]),
      .nbr_value   (row_value[i+1]),
      .nbr_age     (row_age[i+1]),
      .prev_keep   (row_keep[i]),
      .keep        (row_keep[i+1]),
      .state_valid (row_valid[i]),
      .state_value (row_value[i]),
      .state_age   (row_age[i]),
      .nxt_value   (row_nxt[i]),
      .expired     (row_exp[i])
    );
  end

  // Effective window, clamped to 1..MAX_WINDOW at write time.
  always_comb begin
    if (cfg_window_size == '0) begin
      win_nxt = AGE_WIDTH'(1);
    end else if (int'(cfg_window_size) > MAX_WINDOW) begin
      win_nxt = AGE_WIDTH'(MAX_WINDOW);
    end else begin
      win_nxt = AGE_WIDTH'(cfg_window_size);
    end
  end

  // Sample count saturates at the window size.
  always_comb begin
    seen_base = in_start_sequence ? '0 : seen_r;
    seen_nxt  = (seen_base < win_r) ? AGE_WIDTH'(seen_base + 1'b1) : seen_base;
    emit      = (seen_nxt >= win_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r  <= AGE_WIDTH'(1);
      seen_r <= '0;
    end else if (cfg_fire) begin
      win_r  <= win_nxt;
      seen_r <= '0;
    end else if (in_fire) begin
      seen_r <= seen_nxt;
    end
  end

  // Output register: front of the queue after this word is appended.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= emit;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_max_r <= row_nxt[0];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_window_max = out_max_r;

endmodule
